/* sv/grid_shortest_path_search_core_macros.svh */
// Assertion macros for the grid shortest-path search core.
`ifndef GRID_SHORTEST_PATH_SEARCH_CORE_MACROS_SVH
`define GRID_SHORTEST_PATH_SEARCH_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define GSP_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("gsp check failed");
`define GSP_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("gsp check failed");
`else
`define GSP_ASSERT_SAME(label, pre, post)
`define GSP_ASSERT_NEXT(label, pre, post)
`endif
`endif

/* sv/gsp_pkg.sv */
// Shared constants for the grid shortest-path search core.
package gsp_pkg;
    localparam int COORD_W = 5;
    localparam int SIZE_W  = 6;
    localparam int DIST_W  = 11;
    localparam int POPS_W  = 11;

    typedef logic [1:0] command_t;
    localparam command_t CMD_LOAD = 2'd0;
    localparam command_t CMD_RUN  = 2'd1;
    localparam command_t CMD_READ = 2'd2;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef logic [1:0] dir_t;
    localparam dir_t DIR_UP    = 2'd0;
    localparam dir_t DIR_DOWN  = 2'd1;
    localparam dir_t DIR_LEFT  = 2'd2;
    localparam dir_t DIR_RIGHT = 2'd3;

    localparam logic [DIST_W-1:0] UNREACHED = '1;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;
endpackage

/* sv/grid_shortest_path_search_core.sv */
// Grid shortest-path search core: unit-cost Dijkstra over a 4-connected grid.
//
// A user drives start with a command; it is taken when busy is low. Cell loads
// give no result. A path-mark read gives its result in the next cycle, and reads
// stream one per cycle. A run raises busy for its whole length: first a clearing
// pass over every storage cell (GRID_SIDE rounded up to a power of two per side)
// that resets distances, visited flags and path marks, then a setup step and the
// search itself. Each pop scans the open list, reading and then comparing each
// entry, then reads the last entry and moves it into the hole, and reads and
// checks the visited flag of the popped cell; a fresh pop then reads each
// neighbor direction in turn and updates each neighbor inside the grid, a stale
// pop skips that, and either then picks the next step unless a fresh pop reached
// the goal. The traceback marks each cell back to the start, stepping against its
// parent direction, and the answer follows. Results appear for exactly one cycle on
// result_valid and cannot be held off; a run answer comes in the cycle busy falls.
`include "grid_shortest_path_search_core_macros.svh"
module grid_shortest_path_search_core #(
    parameter int GRID_SIDE = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  gsp_pkg::command_t           command,
    input  logic [gsp_pkg::COORD_W-1:0] cell_row,
    input  logic [gsp_pkg::COORD_W-1:0] cell_col,
    input  logic                        cell_blocked,
    input  logic [gsp_pkg::COORD_W-1:0] start_row,
    input  logic [gsp_pkg::COORD_W-1:0] start_col,
    input  logic [gsp_pkg::COORD_W-1:0] goal_row,
    input  logic [gsp_pkg::COORD_W-1:0] goal_col,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [gsp_pkg::SIZE_W-1:0]  cfg_data,
    output logic                        result_valid,
    output logic                        is_search_result,
    output logic                        path_found,
    output logic [gsp_pkg::POPS_W-1:0]  nodes_explored,
    output logic                        cell_on_path
);
    import gsp_pkg::*;

    localparam int CW    = $clog2(GRID_SIDE);
    localparam int VW    = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;
    localparam int OPEN_DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int OW    = $clog2(OPEN_DEPTH);
    localparam int CNTW  = OW + 1;
    localparam int EW    = 2 * CW + DIST_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CLEAR   = 4'd1;
    localparam logic [3:0] S_INIT    = 4'd2;
    localparam logic [3:0] S_SCAN_RD = 4'd3;
    localparam logic [3:0] S_SCAN_CM = 4'd4;
    localparam logic [3:0] S_LAST_RD = 4'd5;
    localparam logic [3:0] S_LAST_WR = 4'd6;
    localparam logic [3:0] S_VIS_RD  = 4'd7;
    localparam logic [3:0] S_VIS_CHK = 4'd8;
    localparam logic [3:0] S_NB_RD   = 4'd9;
    localparam logic [3:0] S_NB_UPD  = 4'd10;
    localparam logic [3:0] S_NEXT    = 4'd11;
    localparam logic [3:0] S_TR_RD   = 4'd12;
    localparam logic [3:0] S_TR_STEP = 4'd13;
    localparam logic [3:0] S_DONE    = 4'd14;

    localparam logic [VW-1:0] SIDE_V = VW'(GRID_SIDE);

    // Control and datapath registers
    logic [3:0]         state_reg, state_next;
    logic [SIZE_W-1:0]  rows_reg, rows_next, cols_reg, cols_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [COORD_W-1:0] sr_reg, sr_next, sc_reg, sc_next;
    logic [COORD_W-1:0] gr_reg, gr_next, gc_reg, gc_next;
    logic [CNTW-1:0]    count_reg, count_next;
    logic [OW-1:0]      scan_reg, scan_next, best_idx_reg, best_idx_next;
    logic [CW-1:0]      best_r_reg, best_r_next, best_c_reg, best_c_next;
    logic [DIST_W-1:0]  best_cost_reg, best_cost_next, cur_dist_reg, cur_dist_next;
    dir_t               dir_reg, dir_next;
    logic [CW-1:0]      nxt_r_reg, nxt_r_next, nxt_c_reg, nxt_c_next;
    logic [CW-1:0]      tr_r_reg, tr_r_next, tr_c_reg, tr_c_next;
    logic [POPS_W-1:0]  pops_reg, pops_next;
    logic               found_reg, found_next;
    logic               live_reg, live_next;
    logic               srch_v_reg, srch_v_next;
    logic               rd_v_reg, rd_v_next, rd_in_reg, rd_in_next;

    // Memories
    logic               wall_mem [DEPTH];
    logic [DIST_W-1:0]  dist_mem [DEPTH];
    logic               vis_mem  [DEPTH];
    dir_t               par_mem  [DEPTH];
    logic               mark_mem [DEPTH];
    logic [EW-1:0]      open_mem [OPEN_DEPTH];

    logic wall_we, dist_we, vis_we, par_we, mark_we, open_we;
    logic [AW-1:0] wall_wa, dist_wa, vis_wa, par_wa, mark_wa, look_ra, par_ra, mark_ra;
    logic wall_wd, vis_wd, mark_wd;
    logic [DIST_W-1:0] dist_wd;
    logic [OW-1:0] open_wa, open_ra;
    logic [EW-1:0] open_wd;
    logic wall_q, vis_q, mark_q;
    logic [DIST_W-1:0] dist_q;
    dir_t par_q;
    logic [EW-1:0] open_q;

    // Derived values
    logic [VW-1:0] rows_v, cols_v, cell_r_v, cell_c_v;
    logic [VW-1:0] nb_r, nb_c, st_r, st_c;
    logic          cell_in, start_in, nb_in, st_out, at_goal, at_start;
    logic [AW-1:0] cell_addr, cur_addr, nb_addr, tr_addr;
    logic [CW-1:0] q_r, q_c;
    logic [DIST_W-1:0] q_cost, step_cost;

    assign rows_v = (VW'(rows_reg) > SIDE_V) ? SIDE_V : VW'(rows_reg);
    assign cols_v = (VW'(cols_reg) > SIDE_V) ? SIDE_V : VW'(cols_reg);
    assign cell_r_v = VW'(cell_row);
    assign cell_c_v = VW'(cell_col);
    // Storage check for loads and reads uses GRID_SIDE, not the configured size
    assign cell_in  = (cell_r_v < SIDE_V) && (cell_c_v < SIDE_V);
    assign cell_addr = {cell_r_v[CW-1:0], cell_c_v[CW-1:0]};
    assign start_in = (VW'(sr_reg) < rows_v) && (VW'(sc_reg) < cols_v);
    assign st_r = VW'(sr_reg);
    assign st_c = VW'(sc_reg);
    assign cur_addr = {best_r_reg, best_c_reg};
    assign tr_addr  = {tr_r_reg, tr_c_reg};
    assign at_goal  = (VW'(best_r_reg) == VW'(gr_reg)) && (VW'(best_c_reg) == VW'(gc_reg));
    assign at_start = (VW'(tr_r_reg) == st_r) && (VW'(tr_c_reg) == st_c);
    assign {q_r, q_c, q_cost} = open_q;
    assign step_cost = cur_dist_reg + DIST_W'(1);

    // Neighbor of the popped cell; a step below zero wraps past the grid size
    always_comb
    begin
        nb_r = VW'(best_r_reg);
        nb_c = VW'(best_c_reg);
        case (dir_reg)
            DIR_UP:    nb_r = VW'(best_r_reg) - VW'(1);
            DIR_DOWN:  nb_r = VW'(best_r_reg) + VW'(1);
            DIR_LEFT:  nb_c = VW'(best_c_reg) - VW'(1);
            DIR_RIGHT: nb_c = VW'(best_c_reg) + VW'(1);
            default:   nb_r = VW'(best_r_reg);
        endcase
    end
    assign nb_in   = (nb_r < rows_v) && (nb_c < cols_v);
    assign nb_addr = {nb_r[CW-1:0], nb_c[CW-1:0]};

    // Traceback step: move against the stored parent direction
    logic [VW-1:0] tb_r, tb_c;
    always_comb
    begin
        tb_r = VW'(tr_r_reg);
        tb_c = VW'(tr_c_reg);
        case (par_q)
            DIR_UP:    tb_r = VW'(tr_r_reg) + VW'(1);
            DIR_DOWN:  tb_r = VW'(tr_r_reg) - VW'(1);
            DIR_LEFT:  tb_c = VW'(tr_c_reg) + VW'(1);
            DIR_RIGHT: tb_c = VW'(tr_c_reg) - VW'(1);
            default:   tb_r = VW'(tr_r_reg);
        endcase
    end
    assign st_out = (tb_r >= rows_v) || (tb_c >= cols_v);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        rows_next = rows_reg;
        cols_next = cols_reg;
        clr_next = clr_reg;
        sr_next = sr_reg;
        sc_next = sc_reg;
        gr_next = gr_reg;
        gc_next = gc_reg;
        count_next = count_reg;
        scan_next = scan_reg;
        best_idx_next = best_idx_reg;
        best_r_next = best_r_reg;
        best_c_next = best_c_reg;
        best_cost_next = best_cost_reg;
        cur_dist_next = cur_dist_reg;
        dir_next = dir_reg;
        nxt_r_next = nxt_r_reg;
        nxt_c_next = nxt_c_reg;
        tr_r_next = tr_r_reg;
        tr_c_next = tr_c_reg;
        pops_next = pops_reg;
        found_next = found_reg;
        live_next = live_reg;
        srch_v_next = 1'b0;
        rd_v_next = 1'b0;
        rd_in_next = rd_in_reg;
        wall_we = 1'b0; wall_wa = cell_addr; wall_wd = cell_blocked;
        dist_we = 1'b0; dist_wa = clr_reg; dist_wd = UNREACHED;
        vis_we = 1'b0; vis_wa = clr_reg; vis_wd = 1'b0;
        mark_we = 1'b0; mark_wa = clr_reg; mark_wd = 1'b0;
        par_we = 1'b0; par_wa = {nxt_r_reg, nxt_c_reg}; par_ra = tr_addr;
        open_we = 1'b0; open_wa = '0; open_wd = open_q;
        open_ra = scan_reg;
        look_ra = cur_addr;
        mark_ra = cell_addr;

        if (cfg_write)
        begin
            if (cfg_index == CFG_ROWS)
                rows_next = cfg_data;
            else
                cols_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (command)
                        CMD_LOAD:
                            wall_we = cell_in;
                        CMD_RUN:
                        begin
                            sr_next = start_row;
                            sc_next = start_col;
                            gr_next = goal_row;
                            gc_next = goal_col;
                            clr_next = '0;
                            pops_next = '0;
                            found_next = 1'b0;
                            count_next = '0;
                            state_next = S_CLEAR;
                        end
                        CMD_READ:
                        begin
                            rd_v_next = 1'b1;
                            rd_in_next = cell_in;
                        end
                        default: ;
                    endcase
                end
            end
            S_CLEAR:
            begin
                dist_we = 1'b1;
                vis_we = 1'b1;
                mark_we = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == '1)
                begin
                    live_next = 1'b1;
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                if (start_in)
                begin
                    dist_we = 1'b1;
                    dist_wa = {st_r[CW-1:0], st_c[CW-1:0]};
                    dist_wd = '0;
                    open_we = 1'b1;
                    open_wa = '0;
                    open_wd = {st_r[CW-1:0], st_c[CW-1:0], DIST_W'(0)};
                    count_next = CNTW'(1);
                    scan_next = '0;
                    state_next = S_SCAN_RD;
                end
                else
                    state_next = S_DONE;
            end
            S_SCAN_RD:
                state_next = S_SCAN_CM;
            S_SCAN_CM:
            begin
                // Keep the first entry of lowest cost
                if (scan_reg == '0 || q_cost < best_cost_reg)
                begin
                    best_idx_next = scan_reg;
                    best_r_next = q_r;
                    best_c_next = q_c;
                    best_cost_next = q_cost;
                end
                if (CNTW'(scan_reg) + CNTW'(1) == count_reg)
                    state_next = S_LAST_RD;
                else
                begin
                    scan_next = scan_reg + OW'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_LAST_RD:
            begin
                open_ra = OW'(count_reg - CNTW'(1));
                state_next = S_LAST_WR;
            end
            S_LAST_WR:
            begin
                // Move the last entry into the hole left by the pop
                open_we = 1'b1;
                open_wa = best_idx_reg;
                open_wd = open_q;
                count_next = count_reg - CNTW'(1);
                pops_next = pops_reg + POPS_W'(1);
                state_next = S_VIS_RD;
            end
            S_VIS_RD:
                state_next = S_VIS_CHK;
            S_VIS_CHK:
            begin
                if (vis_q)
                    state_next = S_NEXT;
                else
                begin
                    vis_we = 1'b1;
                    vis_wa = cur_addr;
                    vis_wd = 1'b1;
                    cur_dist_next = dist_q;
                    if (at_goal)
                    begin
                        tr_r_next = best_r_reg;
                        tr_c_next = best_c_reg;
                        state_next = S_TR_RD;
                    end
                    else
                    begin
                        dir_next = DIR_UP;
                        state_next = S_NB_RD;
                    end
                end
            end
            S_NB_RD:
            begin
                look_ra = nb_addr;
                if (nb_in)
                begin
                    nxt_r_next = nb_r[CW-1:0];
                    nxt_c_next = nb_c[CW-1:0];
                    state_next = S_NB_UPD;
                end
                else if (dir_reg == DIR_RIGHT)
                    state_next = S_NEXT;
                else
                    dir_next = dir_reg + 2'd1;
            end
            S_NB_UPD:
            begin
                if (!vis_q && !wall_q && step_cost < dist_q)
                begin
                    dist_we = 1'b1;
                    dist_wa = {nxt_r_reg, nxt_c_reg};
                    dist_wd = step_cost;
                    open_we = 1'b1;
                    open_wa = OW'(count_reg);
                    open_wd = {nxt_r_reg, nxt_c_reg, step_cost};
                    count_next = count_reg + CNTW'(1);
                    par_we = 1'b1;
                end
                if (dir_reg == DIR_RIGHT)
                    state_next = S_NEXT;
                else
                begin
                    dir_next = dir_reg + 2'd1;
                    state_next = S_NB_RD;
                end
            end
            S_NEXT:
            begin
                scan_next = '0;
                state_next = (count_reg == '0) ? S_DONE : S_SCAN_RD;
            end
            S_TR_RD:
            begin
                if (at_start)
                begin
                    found_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    mark_we = 1'b1;
                    mark_wa = tr_addr;
                    mark_wd = 1'b1;
                    state_next = S_TR_STEP;
                end
            end
            S_TR_STEP:
            begin
                if (st_out)
                begin
                    found_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    tr_r_next = tb_r[CW-1:0];
                    tr_c_next = tb_c[CW-1:0];
                    state_next = S_TR_RD;
                end
            end
            S_DONE:
            begin
                srch_v_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rows_reg <= SIZE_RESET;
            cols_reg <= SIZE_RESET;
            count_reg <= '0;
            live_reg <= 1'b0;
            srch_v_reg <= 1'b0;
            rd_v_reg <= 1'b0;
            found_reg <= 1'b0;
            pops_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rows_reg <= rows_next;
            cols_reg <= cols_next;
            count_reg <= count_next;
            live_reg <= live_next;
            srch_v_reg <= srch_v_next;
            rd_v_reg <= rd_v_next;
            found_reg <= found_next;
            pops_reg <= pops_next;
        end
    end

    always_ff @(posedge clk)
    begin
        clr_reg <= clr_next;
        sr_reg <= sr_next;
        sc_reg <= sc_next;
        gr_reg <= gr_next;
        gc_reg <= gc_next;
        scan_reg <= scan_next;
        best_idx_reg <= best_idx_next;
        best_r_reg <= best_r_next;
        best_c_reg <= best_c_next;
        best_cost_reg <= best_cost_next;
        cur_dist_reg <= cur_dist_next;
        dir_reg <= dir_next;
        nxt_r_reg <= nxt_r_next;
        nxt_c_reg <= nxt_c_next;
        tr_r_reg <= tr_r_next;
        tr_c_reg <= tr_c_next;
        rd_in_reg <= rd_in_next;
    end

    // Memory ports: one write, one registered read each
    always_ff @(posedge clk)
    begin
        if (wall_we)
            wall_mem[wall_wa] <= wall_wd;
        wall_q <= wall_mem[look_ra];
    end

    always_ff @(posedge clk)
    begin
        if (dist_we)
            dist_mem[dist_wa] <= dist_wd;
        dist_q <= dist_mem[look_ra];
    end

    always_ff @(posedge clk)
    begin
        if (vis_we)
            vis_mem[vis_wa] <= vis_wd;
        vis_q <= vis_mem[look_ra];
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
            par_mem[par_wa] <= dir_reg;
        par_q <= par_mem[par_ra];
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
            mark_mem[mark_wa] <= mark_wd;
        mark_q <= mark_mem[mark_ra];
    end

    always_ff @(posedge clk)
    begin
        if (open_we)
            open_mem[open_wa] <= open_wd;
        open_q <= open_mem[open_ra];
    end

    // Outputs: marks read before the first run read as clear
    assign busy             = (state_reg != S_IDLE);
    assign result_valid     = srch_v_reg | rd_v_reg;
    assign is_search_result = srch_v_reg;
    assign path_found       = srch_v_reg & found_reg;
    assign nodes_explored   = srch_v_reg ? pops_reg : '0;
    assign cell_on_path     = rd_v_reg & rd_in_reg & live_reg & mark_q;

    `GSP_ASSERT_SAME(a_run_answer_idle, srch_v_reg, !busy && !rd_v_reg)
    `GSP_ASSERT_NEXT(a_run_goes_busy, start && !busy && command == CMD_RUN, busy)
    `GSP_ASSERT_NEXT(a_read_answers, start && !busy && command == CMD_READ,
                     result_valid && !is_search_result)
    `GSP_ASSERT_SAME(a_open_bounded, 1'b1, count_reg <= CNTW'(OPEN_DEPTH))
endmodule

/* tb/grid_shortest_path_search_core_tb.sv */
// Testbench for the grid shortest-path search core: predicts results and checks them in order.
`timescale 1ns / 1ps

module testbench;
    import gsp_pkg::*;

    localparam int SIDE       = 32;
    localparam int CELLS      = SIDE * SIDE;
    localparam int DRAIN_WAIT = 20;
    localparam longint CYCLE_LIMIT = 40_000_000;

    typedef struct {
        command_t       cmd;
        logic [4:0]     cell_row;
        logic [4:0]     cell_col;
        logic           cell_blocked;
        logic [4:0]     start_row;
        logic [4:0]     start_col;
        logic [4:0]     goal_row;
        logic [4:0]     goal_col;
    } request_t;

    typedef struct {
        logic               is_search;
        logic               found;
        logic [POPS_W-1:0]  pops;
        logic               on_path;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    command_t command = CMD_LOAD;
    logic [COORD_W-1:0] cell_row = '0;
    logic [COORD_W-1:0] cell_col = '0;
    logic cell_blocked = 1'b0;
    logic [COORD_W-1:0] start_row = '0;
    logic [COORD_W-1:0] start_col = '0;
    logic [COORD_W-1:0] goal_row = '0;
    logic [COORD_W-1:0] goal_col = '0;
    logic cfg_write = 1'b0;
    logic cfg_index = CFG_ROWS;
    logic [SIZE_W-1:0] cfg_data = '0;
    logic result_valid;
    logic is_search_result;
    logic path_found;
    logic [POPS_W-1:0] nodes_explored;
    logic cell_on_path;

    grid_shortest_path_search_core u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .command          (command),
        .cell_row         (cell_row),
        .cell_col         (cell_col),
        .cell_blocked     (cell_blocked),
        .start_row        (start_row),
        .start_col        (start_col),
        .goal_row         (goal_row),
        .goal_col         (goal_col),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .result_valid     (result_valid),
        .is_search_result (is_search_result),
        .path_found       (path_found),
        .nodes_explored   (nodes_explored),
        .cell_on_path     (cell_on_path)
    );

    // Shadow copy of the block state, advanced as each request is queued.
    // Requests are accepted strictly in queue order, so this matches the block.
    int  rows_reg = 32;
    int  cols_reg = 32;
    bit  wall_shadow [CELLS];
    int  dist_shadow [CELLS];
    bit  seen_shadow [CELLS];
    dir_t parent_shadow [CELLS];
    bit  mark_shadow [CELLS];
    int  open_row [CELLS];
    int  open_col [CELLS];
    int  open_cost [CELLS];
    int  marked_cells [$];

    request_t pending_requests [$];
    answer_t  expected_answers [$];
    int       idle_pct = 0;
    int       fail_count = 0;
    bit       req_taken = 1'b0;
    longint   cycle_count = 0;

    // Step applied to reach a neighbor, indexed by direction (up, down, left, right).
    function automatic int row_step(dir_t d);
        return (d == DIR_UP) ? -1 : (d == DIR_DOWN) ? 1 : 0;
    endfunction

    function automatic int col_step(dir_t d);
        return (d == DIR_LEFT) ? -1 : (d == DIR_RIGHT) ? 1 : 0;
    endfunction

    function automatic int clamp_size(int reg_value);
        return (reg_value > SIDE) ? SIDE : reg_value;
    endfunction

    // Unit-cost Dijkstra with an unsorted open list; a pop takes the first lowest
    // cost and moves the last entry into the hole. Stale pops are counted too.
    function automatic void search_grid(input int sr, input int sc, input int gr,
                                        input int gc, output bit found, output int pops);
        int rows;
        int cols;
        int open_count;
        int best;
        int at;
        int cur_r;
        int cur_c;
        int nr;
        int nc;
        int nxt;
        int cost;
        int r;
        int c;
        int here;
        dir_t d;
        rows = clamp_size(rows_reg);
        cols = clamp_size(cols_reg);
        found = 1'b0;
        pops = 0;
        for (int i = 0; i < CELLS; i++)
        begin
            seen_shadow[i] = 1'b0;
            mark_shadow[i] = 1'b0;
            dist_shadow[i] = 32'h7FF;
        end
        open_count = 0;
        if (sr >= rows || sc >= cols)
            return;
        dist_shadow[sr * SIDE + sc] = 0;
        open_row[0] = sr;
        open_col[0] = sc;
        open_cost[0] = 0;
        open_count = 1;
        while (open_count > 0)
        begin
            best = 0;
            for (int i = 1; i < open_count; i++)
                if (open_cost[i] < open_cost[best])
                    best = i;
            cur_r = open_row[best];
            cur_c = open_col[best];
            open_count--;
            open_row[best] = open_row[open_count];
            open_col[best] = open_col[open_count];
            open_cost[best] = open_cost[open_count];
            at = cur_r * SIDE + cur_c;
            pops++;
            if (seen_shadow[at])
                continue;
            seen_shadow[at] = 1'b1;
            if (cur_r == gr && cur_c == gc)
            begin
                // Walk parents back from the goal; the start itself stays unmarked.
                r = gr;
                c = gc;
                while (!(r == sr && c == sc))
                begin
                    here = r * SIDE + c;
                    d = parent_shadow[here];
                    mark_shadow[here] = 1'b1;
                    r = r - row_step(d);
                    c = c - col_step(d);
                    if (r < 0 || c < 0 || r >= rows || c >= cols)
                        break;
                end
                found = 1'b1;
                return;
            end
            for (int k = 0; k < 4; k++)
            begin
                d = dir_t'(k);
                nr = cur_r + row_step(d);
                nc = cur_c + col_step(d);
                if (nr < 0 || nc < 0 || nr >= rows || nc >= cols)
                    continue;
                nxt = nr * SIDE + nc;
                if (seen_shadow[nxt] || wall_shadow[nxt])
                    continue;
                cost = dist_shadow[at] + 1;
                if (cost < dist_shadow[nxt])
                begin
                    dist_shadow[nxt] = cost & 32'h7FF;
                    // Drop a push into a full list
                    if (open_count < CELLS)
                    begin
                        open_row[open_count] = nr;
                        open_col[open_count] = nc;
                        open_cost[open_count] = cost;
                        open_count++;
                    end
                    parent_shadow[nxt] = d;
                end
            end
        end
    endfunction

    // Queue one request and the answer it should produce, if any.
    task automatic queue_request(request_t req);
        answer_t ans;
        bit found;
        int pops;
        ans = '{default: '0};
        pending_requests.push_back(req);
        case (req.cmd)
            CMD_LOAD:
                wall_shadow[req.cell_row * SIDE + req.cell_col] = req.cell_blocked;
            CMD_RUN:
            begin
                search_grid(int'(req.start_row), int'(req.start_col), int'(req.goal_row),
                            int'(req.goal_col), found, pops);
                ans.is_search = 1'b1;
                ans.found = found;
                ans.pops = pops[POPS_W-1:0];
                expected_answers.push_back(ans);
                marked_cells.delete();
                for (int i = 0; i < CELLS; i++)
                    if (mark_shadow[i])
                        marked_cells.push_back(i);
            end
            CMD_READ:
            begin
                ans.on_path = mark_shadow[req.cell_row * SIDE + req.cell_col];
                expected_answers.push_back(ans);
            end
            default: ;
        endcase
    endtask

    function automatic request_t make_request(command_t cmd, int r, int c, int blk,
                                              int sr, int sc, int gr, int gc);
        request_t req;
        req.cmd = cmd;
        req.cell_row = r[4:0];
        req.cell_col = c[4:0];
        req.cell_blocked = blk[0];
        req.start_row = sr[4:0];
        req.start_col = sc[4:0];
        req.goal_row = gr[4:0];
        req.goal_col = gc[4:0];
        return req;
    endfunction

    // Hold until every queued request is taken and every answer has come back,
    // then let the block settle before touching the size registers.
    task automatic wait_drained();
        while (pending_requests.size() > 0 || start || expected_answers.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_size(logic idx, int value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[SIZE_W-1:0];
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_ROWS)
            rows_reg = value & 63;
        else
            cols_reg = value & 63;
    endtask

    task automatic random_phase(int count);
        int rows;
        int cols;
        int run_pct;
        int pick;
        int sr;
        int sc;
        int gr;
        int gc;
        int idx;
        rows = clamp_size(rows_reg);
        cols = clamp_size(cols_reg);
        run_pct = (rows * cols > 256) ? 3 : 18;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < run_pct)
            begin
                // Mostly in-grid endpoints; some anywhere in storage.
                if (rows > 0 && cols > 0 && $urandom_range(9) < 8)
                begin
                    sr = $urandom_range(rows - 1);
                    sc = $urandom_range(cols - 1);
                    gr = $urandom_range(rows - 1);
                    gc = $urandom_range(cols - 1);
                    if ($urandom_range(9) == 0)
                    begin
                        gr = sr;
                        gc = sc;
                    end
                end
                else
                begin
                    sr = $urandom_range(31);
                    sc = $urandom_range(31);
                    gr = $urandom_range(31);
                    gc = $urandom_range(31);
                end
                queue_request(make_request(CMD_RUN, $urandom_range(31), $urandom_range(31),
                                           $urandom_range(1), sr, sc, gr, gc));
            end
            else if (pick < run_pct + 37)
            begin
                // Path cells are the interesting reads; mix in arbitrary ones.
                if (marked_cells.size() > 0 && $urandom_range(1))
                begin
                    idx = marked_cells[$urandom_range(marked_cells.size() - 1)];
                    sr = idx / SIDE;
                    sc = idx % SIDE;
                end
                else
                begin
                    sr = $urandom_range(31);
                    sc = $urandom_range(31);
                end
                queue_request(make_request(CMD_READ, sr, sc, $urandom_range(1),
                                           $urandom_range(31), $urandom_range(31),
                                           $urandom_range(31), $urandom_range(31)));
            end
            else if (pick < 96)
            begin
                if (rows > 0 && cols > 0 && $urandom_range(3) != 0)
                begin
                    sr = $urandom_range(rows - 1);
                    sc = $urandom_range(cols - 1);
                end
                else
                begin
                    sr = $urandom_range(31);
                    sc = $urandom_range(31);
                end
                queue_request(make_request(CMD_LOAD, sr, sc, int'($urandom_range(99) < 25),
                                           $urandom_range(31), $urandom_range(31),
                                           $urandom_range(31), $urandom_range(31)));
            end
            else
            begin
                queue_request(make_request(command_t'(2'd3), $urandom_range(31),
                                           $urandom_range(31), $urandom_range(1),
                                           $urandom_range(31), $urandom_range(31),
                                           $urandom_range(31), $urandom_range(31)));
            end
        end
    endtask

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Stimulus: clear the whole wall map first so no run ever reads an
    // unloaded cell, then directed corners, then random phases per grid size.
    initial
    begin
        int size_rows [10] = '{1, 0, 5, 4, 8, 63, 2, 6, 7, 32};
        int size_cols [10] = '{1, 7, 0, 6, 8, 2, 40, 3, 7, 32};
        int idle_plan [4] = '{0, 85, 0, 32};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < CELLS; i++)
            queue_request(make_request(CMD_LOAD, i / SIDE, i % SIDE, 0, 0, 0, 0, 0));
        // Open grid: the far corner is the last cell popped, so all 1024 pop.
        queue_request(make_request(CMD_RUN, 0, 0, 0, 0, 0, 31, 31));
        queue_request(make_request(CMD_READ, 31, 31, 0, 0, 0, 0, 0));
        queue_request(make_request(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
        queue_request(make_request(CMD_READ, 0, 1, 0, 0, 0, 0, 0));
        queue_request(make_request(command_t'(2'd3), 31, 31, 1, 31, 31, 31, 31));
        queue_request(make_request(CMD_RUN, 31, 31, 1, 5, 5, 5, 5));
        queue_request(make_request(CMD_READ, 5, 5, 0, 0, 0, 0, 0));
        // Blocked goal drains the list without finding it.
        queue_request(make_request(CMD_LOAD, 31, 31, 1, 0, 0, 0, 0));
        queue_request(make_request(CMD_RUN, 0, 0, 0, 0, 0, 31, 31));
        queue_request(make_request(CMD_READ, 31, 31, 1, 0, 0, 0, 0));
        // Blocked start still searches outward.
        queue_request(make_request(CMD_LOAD, 0, 0, 1, 0, 0, 0, 0));
        queue_request(make_request(CMD_RUN, 0, 0, 0, 0, 0, 0, 3));
        queue_request(make_request(CMD_READ, 0, 3, 0, 0, 0, 0, 0));
        queue_request(make_request(CMD_LOAD, 0, 0, 0, 0, 0, 0, 0));
        queue_request(make_request(CMD_LOAD, 31, 31, 0, 0, 0, 0, 0));
        random_phase(10);

        for (int p = 0; p < 10; p++)
        begin
            wait_drained();
            write_size(CFG_ROWS, size_rows[p]);
            write_size(CFG_COLS, size_cols[p]);
            idle_pct = idle_plan[p % 4];
            // Start outside the grid: nothing pushed, marks still cleared.
            if (p == 2)
                queue_request(make_request(CMD_RUN, 0, 0, 0, 6, 0, 0, 0));
            random_phase((p == 9) ? 10 : 8);
        end

        wait_drained();
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Driver: present the next request at the falling edge; hold it until taken.
    always @(negedge clk)
    begin
        request_t req;
        if (start && !req_taken)
            ;
        else if (rst_n && pending_requests.size() > 0 && $urandom_range(99) >= idle_pct)
        begin
            req = pending_requests.pop_front();
            start <= 1'b1;
            command <= req.cmd;
            cell_row <= req.cell_row;
            cell_col <= req.cell_col;
            cell_blocked <= req.cell_blocked;
            start_row <= req.start_row;
            start_col <= req.start_col;
            goal_row <= req.goal_row;
            goal_col <= req.goal_col;
        end
        else
            start <= 1'b0;
    end

    // Monitor: note request acceptance and compare each answer with the oldest expectation.
    always @(posedge clk)
    begin
        answer_t exp_ans;
        req_taken = start && !busy;
        if (rst_n && result_valid)
        begin
            if (expected_answers.size() == 0)
            begin
                $error("unexpected answer: is_search_result=%0d", is_search_result);
                fail_count++;
            end
            else
            begin
                exp_ans = expected_answers.pop_front();
                if (is_search_result !== exp_ans.is_search)
                begin
                    $error("is_search_result expected %0d got %0d",
                           exp_ans.is_search, is_search_result);
                    fail_count++;
                end
                if (path_found !== exp_ans.found)
                begin
                    $error("path_found expected %0d got %0d", exp_ans.found, path_found);
                    fail_count++;
                end
                if (nodes_explored !== exp_ans.pops)
                begin
                    $error("nodes_explored expected %0d got %0d",
                           exp_ans.pops, nodes_explored);
                    fail_count++;
                end
                if (cell_on_path !== exp_ans.on_path)
                begin
                    $error("cell_on_path expected %0d got %0d",
                           exp_ans.on_path, cell_on_path);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: a hung search ends the run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end
endmodule
